### rtl/cll_pkg.sv
// shared types and constants for the circular linked list manager
`timescale 1ns / 1ps

package cll_pkg;

   localparam int CAPACITY = 256;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = SLOT_W + 1;
   localparam int VALUE_W  = 32;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_FIX
   } state_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_INSERT_EMPTY,
      OP_INSERT_FULL,
      OP_REMOVE,
      OP_REMOVE_ONE,
      OP_REMOVE_EMPTY
   } op_type;

   // free stack access: one pop read and one push write
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_idx;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_idx;
      logic [SLOT_W-1:0] wr_data;
   } stk_cmd_type;

   // link and value memory access
   typedef struct packed {
      logic                      rd_en;
      logic [SLOT_W-1:0]         rd_addr;
      logic                      next_we;
      logic [SLOT_W-1:0]         next_waddr;
      logic [SLOT_W-1:0]         next_wdata;
      logic                      prev_we;
      logic [SLOT_W-1:0]         prev_waddr;
      logic [SLOT_W-1:0]         prev_wdata;
      logic                      val_we;
      logic [SLOT_W-1:0]         val_waddr;
      logic signed [VALUE_W-1:0] val_wdata;
   } link_cmd_type;

endpackage

### rtl/cll_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module cll_ram #(
   parameter int WIDTH = cll_pkg::SLOT_W,
   parameter int DEPTH = cll_pkg::CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cll_free_stack.sv
// lifo stack of free slots with a low-water mark standing in for its reset image
`timescale 1ns / 1ps

module cll_free_stack (
   input  logic                        clock,
   input  logic                        reset,
   input  cll_pkg::stk_cmd_type        cmd,
   output logic [cll_pkg::SLOT_W-1:0]  slot
);

   logic [cll_pkg::COUNT_W-1:0] min_top_ff;
   logic [cll_pkg::COUNT_W-1:0] min_top_in;
   logic                        init_hit_ff;
   logic [cll_pkg::SLOT_W-1:0]  init_val_ff;
   logic [cll_pkg::SLOT_W-1:0]  ram_data;
   logic                        below_mark;

   cll_ram #(
      .WIDTH (cll_pkg::SLOT_W),
      .DEPTH (cll_pkg::CAPACITY)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_idx),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_idx),
      .rd_data (ram_data)
   );

   // an entry below the lowest top ever reached has never been pushed
   assign below_mark = {1'b0, cmd.rd_idx} < min_top_ff;

   always_comb begin
      min_top_in = min_top_ff;
      if (cmd.rd_en && below_mark) begin
         min_top_in = {1'b0, cmd.rd_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_top_ff <= cll_pkg::COUNT_W'(cll_pkg::CAPACITY);
      end else begin
         min_top_ff <= min_top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         init_hit_ff <= below_mark;
         init_val_ff <= cll_pkg::SLOT_W'(cll_pkg::CAPACITY - 1) - cmd.rd_idx;
      end
   end

   assign slot = init_hit_ff ? init_val_ff : ram_data;

endmodule

### rtl/cll_ctrl.sv
// request sequencer: reads links, then writes them back in the ST_LINK and ST_FIX states
`timescale 1ns / 1ps

module cll_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [cll_pkg::SLOT_W-1:0]         req_node_index,
   input  logic signed [cll_pkg::VALUE_W-1:0] req_item_value,
   output cll_pkg::stk_cmd_type               stk_cmd,
   input  logic [cll_pkg::SLOT_W-1:0]         stk_slot,
   output cll_pkg::link_cmd_type              link_cmd,
   input  logic [cll_pkg::SLOT_W-1:0]         next_rd_data,
   input  logic [cll_pkg::SLOT_W-1:0]         prev_rd_data,
   output logic                               rsp_valid,
   output logic [cll_pkg::SLOT_W-1:0]         rsp_new_slot,
   output logic [1:0]                         rsp_status,
   output logic [cll_pkg::COUNT_W-1:0]        rsp_element_count
);

   cll_pkg::state_type                  state_ff, state_in;
   cll_pkg::op_type                     op_ff, op_in;
   logic [cll_pkg::SLOT_W-1:0]          node_ff, node_in;
   logic signed [cll_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [cll_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic [cll_pkg::SLOT_W-1:0]          after_ff, after_in;
   logic [cll_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [cll_pkg::SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic [cll_pkg::COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [cll_pkg::COUNT_W-1:0]         free_top;

   assign free_top = cll_pkg::COUNT_W'(cll_pkg::CAPACITY) - count_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      node_in       = node_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      after_in      = after_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      stk_cmd       = '0;
      link_cmd      = '0;

      unique case (state_ff)
         cll_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == cll_pkg::REQ_INSERT) begin
                  if (count_ff == cll_pkg::COUNT_W'(cll_pkg::CAPACITY)) begin
                     op_in = cll_pkg::OP_INSERT_FULL;
                  end else if (count_ff == '0) begin
                     op_in = cll_pkg::OP_INSERT_EMPTY;
                  end else begin
                     op_in = cll_pkg::OP_INSERT;
                  end
               end else begin
                  if (count_ff == '0) begin
                     op_in = cll_pkg::OP_REMOVE_EMPTY;
                  end else if (count_ff == cll_pkg::COUNT_W'(1)) begin
                     op_in = cll_pkg::OP_REMOVE_ONE;
                  end else begin
                     op_in = cll_pkg::OP_REMOVE;
                  end
               end
               // pop read at free_top - 1, issued only when a slot is there
               stk_cmd.rd_en = (req_type == cll_pkg::REQ_INSERT) &&
                               (count_ff != cll_pkg::COUNT_W'(cll_pkg::CAPACITY));
               stk_cmd.rd_idx   = cll_pkg::SLOT_W'(free_top - cll_pkg::COUNT_W'(1));
               link_cmd.rd_en   = 1'b1;
               link_cmd.rd_addr = req_node_index;
               node_in  = req_node_index;
               value_in = req_item_value;
               state_in = cll_pkg::ST_LINK;
            end
         end

         cll_pkg::ST_LINK: begin
            slot_in  = stk_slot;
            after_in = next_rd_data;
            unique case (op_ff)
               cll_pkg::OP_INSERT: begin
                  link_cmd.val_we     = 1'b1;
                  link_cmd.val_waddr  = stk_slot;
                  link_cmd.val_wdata  = value_ff;
                  link_cmd.next_we    = 1'b1;
                  link_cmd.next_waddr = node_ff;
                  link_cmd.next_wdata = stk_slot;
                  link_cmd.prev_we    = 1'b1;
                  link_cmd.prev_waddr = stk_slot;
                  link_cmd.prev_wdata = node_ff;
                  count_in = count_ff + cll_pkg::COUNT_W'(1);
               end
               cll_pkg::OP_INSERT_EMPTY: begin
                  link_cmd.val_we     = 1'b1;
                  link_cmd.val_waddr  = stk_slot;
                  link_cmd.val_wdata  = value_ff;
                  link_cmd.next_we    = 1'b1;
                  link_cmd.next_waddr = stk_slot;
                  link_cmd.next_wdata = stk_slot;
                  link_cmd.prev_we    = 1'b1;
                  link_cmd.prev_waddr = stk_slot;
                  link_cmd.prev_wdata = stk_slot;
                  count_in = count_ff + cll_pkg::COUNT_W'(1);
               end
               cll_pkg::OP_REMOVE: begin
                  // bypass the node: next[before] = after, prev[after] = before
                  link_cmd.next_we    = 1'b1;
                  link_cmd.next_waddr = prev_rd_data;
                  link_cmd.next_wdata = next_rd_data;
                  link_cmd.prev_we    = 1'b1;
                  link_cmd.prev_waddr = next_rd_data;
                  link_cmd.prev_wdata = prev_rd_data;
                  stk_cmd.wr_en   = 1'b1;
                  stk_cmd.wr_idx  = cll_pkg::SLOT_W'(free_top);
                  stk_cmd.wr_data = node_ff;
                  count_in = count_ff - cll_pkg::COUNT_W'(1);
               end
               cll_pkg::OP_REMOVE_ONE: begin
                  stk_cmd.wr_en   = 1'b1;
                  stk_cmd.wr_idx  = cll_pkg::SLOT_W'(free_top);
                  stk_cmd.wr_data = node_ff;
                  count_in = count_ff - cll_pkg::COUNT_W'(1);
               end
               default: begin
               end
            endcase
            state_in = cll_pkg::ST_FIX;
         end

         cll_pkg::ST_FIX: begin
            if (op_ff == cll_pkg::OP_INSERT) begin
               link_cmd.next_we    = 1'b1;
               link_cmd.next_waddr = slot_ff;
               link_cmd.next_wdata = after_ff;
               link_cmd.prev_we    = 1'b1;
               link_cmd.prev_waddr = after_ff;
               link_cmd.prev_wdata = slot_ff;
            end
            rsp_valid_in = 1'b1;
            rsp_slot_in  = (op_ff == cll_pkg::OP_INSERT || op_ff == cll_pkg::OP_INSERT_EMPTY)
                           ? slot_ff : '0;
            if (op_ff == cll_pkg::OP_INSERT_FULL) begin
               rsp_status_in = cll_pkg::STATUS_FULL;
            end else if (op_ff == cll_pkg::OP_REMOVE_EMPTY) begin
               rsp_status_in = cll_pkg::STATUS_EMPTY;
            end else begin
               rsp_status_in = cll_pkg::STATUS_DONE;
            end
            rsp_count_in = count_ff;
            state_in     = cll_pkg::ST_IDLE;
         end

         default: begin
            state_in = cll_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cll_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      node_ff       <= node_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      after_ff      <= after_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy              = (state_ff != cll_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_slot      = rsp_slot_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

### rtl/circular_linked_list_manager.sv
// top level of the circular doubly linked list manager
//
// Requests enter on start while busy is low: req_type selects insert (0) or
// remove (1), req_node_index names the anchor node or the node to remove,
// req_item_value is stored in the new node on insert.
// Every request gives exactly one response, shown for a single cycle with
// rsp_valid high: rsp_new_slot (slot taken by an insert, else zero),
// rsp_status (done, list full, remove on empty list) and rsp_element_count.
// The receiver has no way to stall; a response is taken in its one cycle.
// The response is registered after the ST_LINK and ST_FIX states; busy is low
// in the same cycle as the response, so a new request is taken only after the
// last one is answered. The three steps are a link read, a first link write-back
// and a second link write-back, each limited to one write per link memory.
// Synchronous reset empties the list and refills the free stack at once,
// with slots 0, 1, 2 and so on handed out first; no clearing pass is needed.
// Link and value entries stay undefined until an insert writes them.
`timescale 1ns / 1ps

module circular_linked_list_manager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [cll_pkg::SLOT_W-1:0]         req_node_index,
   input  logic signed [cll_pkg::VALUE_W-1:0] req_item_value,
   output logic                               rsp_valid,
   output logic [cll_pkg::SLOT_W-1:0]         rsp_new_slot,
   output logic [1:0]                         rsp_status,
   output logic [cll_pkg::COUNT_W-1:0]        rsp_element_count
);

   cll_pkg::stk_cmd_type        stk_cmd;
   cll_pkg::link_cmd_type       link_cmd;
   logic [cll_pkg::SLOT_W-1:0]  stk_slot;
   logic [cll_pkg::SLOT_W-1:0]  next_rd_data;
   logic [cll_pkg::SLOT_W-1:0]  prev_rd_data;

   cll_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_node_index    (req_node_index),
      .req_item_value    (req_item_value),
      .stk_cmd           (stk_cmd),
      .stk_slot          (stk_slot),
      .link_cmd          (link_cmd),
      .next_rd_data      (next_rd_data),
      .prev_rd_data      (prev_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_new_slot      (rsp_new_slot),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   cll_free_stack u_free_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .slot  (stk_slot)
   );

   cll_ram #(
      .WIDTH (cll_pkg::SLOT_W),
      .DEPTH (cll_pkg::CAPACITY)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (link_cmd.next_we),
      .wr_addr (link_cmd.next_waddr),
      .wr_data (link_cmd.next_wdata),
      .rd_en   (link_cmd.rd_en),
      .rd_addr (link_cmd.rd_addr),
      .rd_data (next_rd_data)
   );

   cll_ram #(
      .WIDTH (cll_pkg::SLOT_W),
      .DEPTH (cll_pkg::CAPACITY)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (link_cmd.prev_we),
      .wr_addr (link_cmd.prev_waddr),
      .wr_data (link_cmd.prev_wdata),
      .rd_en   (link_cmd.rd_en),
      .rd_addr (link_cmd.rd_addr),
      .rd_data (prev_rd_data)
   );

   // node payload store, kept for the list contents
   cll_ram #(
      .WIDTH (cll_pkg::VALUE_W),
      .DEPTH (cll_pkg::CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (link_cmd.val_we),
      .wr_addr (link_cmd.val_waddr),
      .wr_data (link_cmd.val_wdata),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

endmodule

### rtl/cll_checker.sv
// port-level checks for the circular linked list manager, bound to the top level
`timescale 1ns / 1ps

module cll_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [cll_pkg::SLOT_W-1:0]         rsp_new_slot,
   input logic [1:0]                         rsp_status,
   input logic [cll_pkg::COUNT_W-1:0]        rsp_element_count
);

   // each transfer is answered with a response strobe
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid)
      else $error("response missing three cycles after transfer");

   // a taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   // strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // a refused insert only happens at full capacity and allocates nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cll_pkg::STATUS_FULL |->
         rsp_element_count == cll_pkg::COUNT_W'(cll_pkg::CAPACITY) && rsp_new_slot == '0)
      else $error("full status with wrong count or slot");

   // an ignored remove leaves an empty list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cll_pkg::STATUS_EMPTY |->
         rsp_element_count == '0 && rsp_new_slot == '0)
      else $error("empty status with nonzero count or slot");

endmodule

bind circular_linked_list_manager cll_checker u_cll_checker (.*);
